[hdl/prime_value_filter_macros.svh]
// assertion helpers for the prime value filter
`ifndef PRIME_VALUE_FILTER_MACROS_SVH
`define PRIME_VALUE_FILTER_MACROS_SVH

// clocked assertion, off while reset is held
`define PVF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define PVF_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/pvf_pkg.sv]
package pvf_pkg;

  localparam int VALUE_WIDTH = 16;
  localparam int CNT_W       = $clog2(VALUE_WIDTH);
  localparam int TDATA_W     = ((VALUE_WIDTH + 7) / 8) * 8;

  typedef logic [VALUE_WIDTH-1:0] value_t;
  typedef logic [CNT_W-1:0]       bit_cnt_t;

  // result of one bit-serial division
  typedef struct packed {
    logic done;
    logic rem_zero;
    logic beyond_root;
  } div_res_t;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_START = 4'b0010,
    S_DIV   = 4'b0100,
    S_EMIT  = 4'b1000
  } state_t;

endpackage

[hdl/pvf_div.sv]
module pvf_div
  import pvf_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  value_t   dividend,
  input  value_t   divisor,
  output div_res_t res
);

  value_t   dvd_r, dvd_nxt;
  value_t   dsr_r, dsr_nxt;
  value_t   rem_r, rem_nxt;
  value_t   quo_r, quo_nxt;
  bit_cnt_t cnt_r, cnt_nxt;
  logic     busy_r, busy_nxt;
  logic     done_r, done_nxt;

  logic [VALUE_WIDTH:0] trial;
  logic [VALUE_WIDTH:0] diff;
  logic                 ge;

  // one quotient bit per cycle, restoring
  assign trial = {rem_r, dvd_r[VALUE_WIDTH-1]};
  assign diff  = trial - {1'b0, dsr_r};
  assign ge    = trial >= {1'b0, dsr_r};

  always_comb begin
    dvd_nxt  = dvd_r;
    dsr_nxt  = dsr_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      dvd_nxt  = dividend;
      dsr_nxt  = divisor;
      rem_nxt  = '0;
      quo_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[VALUE_WIDTH-1:0] : trial[VALUE_WIDTH-1:0];
      quo_nxt = {quo_r[VALUE_WIDTH-2:0], ge};
      dvd_nxt = {dvd_r[VALUE_WIDTH-2:0], 1'b0};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(VALUE_WIDTH - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    dsr_r <= dsr_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // divisor above quotient means divisor squared exceeds the dividend
  assign res.done        = done_r;
  assign res.rem_zero    = (rem_r == '0);
  assign res.beyond_root = (dsr_r > quo_r);

endmodule

[hdl/prime_value_filter.sv]
// negative values, zero and one skip the divider; other values run one division per trial divisor
// trial divisors run 2 up to one past the square root, at most 180 for 16 bits
// one element at a time; the bit-serial remainder unit computes one bit per cycle
// a finished result waits in the output register while the next element is taken
// reset: synchronous active-low rst_n clears the state machine and output valid
`include "prime_value_filter_macros.svh"

module prime_value_filter
  import pvf_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [TDATA_W-1:0] in_tdata,  // element_value
  input  logic               in_tlast,  // end_of_matrix
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [TDATA_W-1:0] out_tdata, // prime_value
  output logic               out_tuser, // is_prime
  output logic               out_tlast  // last_result
);

  state_t   state_r, state_nxt;
  value_t   cand_r, cand_nxt;
  value_t   dsr_r, dsr_nxt;
  logic     last_r, last_nxt;
  logic     prime_r, prime_nxt;
  logic     ovalid_r, ovalid_nxt;
  value_t   oval_r, oval_nxt;
  logic     oprime_r, oprime_nxt;
  logic     olast_r, olast_nxt;
  logic     div_start;
  div_res_t div_res;
  logic     in_beat;
  logic     load;
  value_t   in_val;

  assign in_val    = in_tdata[VALUE_WIDTH-1:0];
  assign in_tready = (state_r == S_IDLE);
  assign in_beat   = in_tvalid && in_tready;
  assign div_start = (state_r == S_START);

  pvf_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (cand_r),
    .divisor  (dsr_r),
    .res      (div_res)
  );

  always_comb begin
    state_nxt = state_r;
    cand_nxt  = cand_r;
    dsr_nxt   = dsr_r;
    last_nxt  = last_r;
    prime_nxt = prime_r;
    load      = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_beat) begin
          cand_nxt = in_val;
          last_nxt = in_tlast;
          dsr_nxt  = VALUE_WIDTH'(2);
          if (in_val[VALUE_WIDTH-1] || (in_val[VALUE_WIDTH-1:1] == '0)) begin
            prime_nxt = 1'b0;
            state_nxt = S_EMIT;
          end else begin
            state_nxt = S_START;
          end
        end
      end
      S_START: begin
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_res.done) begin
          if (div_res.beyond_root) begin
            prime_nxt = 1'b1;
            state_nxt = S_EMIT;
          end else if (div_res.rem_zero) begin
            prime_nxt = 1'b0;
            state_nxt = S_EMIT;
          end else begin
            dsr_nxt   = dsr_r + 1'b1;
            state_nxt = S_START;
          end
        end
      end
      S_EMIT: begin
        if (!(prime_r || last_r)) begin
          state_nxt = S_IDLE;
        end else if (!ovalid_r || out_tready) begin
          load      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    ovalid_nxt = ovalid_r && !out_tready;
    oval_nxt   = oval_r;
    oprime_nxt = oprime_r;
    olast_nxt  = olast_r;
    if (load) begin
      ovalid_nxt = 1'b1;
      oval_nxt   = cand_r;
      oprime_nxt = prime_r;
      olast_nxt  = last_r;
    end
  end

  always_ff @(posedge clk) begin
    cand_r   <= cand_nxt;
    dsr_r    <= dsr_nxt;
    last_r   <= last_nxt;
    prime_r  <= prime_nxt;
    oval_r   <= oval_nxt;
    oprime_r <= oprime_nxt;
    olast_r  <= olast_nxt;
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = TDATA_W'(oval_r);
  assign out_tuser  = oprime_r;
  assign out_tlast  = olast_r;

  `PVF_ASSERT(a_done_in_div, div_res.done |-> state_r == S_DIV, "division done outside divide state")
  `PVF_ASSERT(a_neg_to_emit, in_beat && in_val[VALUE_WIDTH-1] |=> state_r == S_EMIT && !prime_r, "negative value not rejected")
  `PVF_ASSERT(a_nonprime_last, out_tvalid && !out_tuser |-> out_tlast, "non-prime result without last")
  `PVF_ASSERT(a_load_free, load |-> !ovalid_r || out_tready, "output overwritten while stalled")

endmodule

[tb/prime_value_filter_checker.sv]
module prime_value_filter_checker
  import pvf_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  input  logic               in_tready,
  input  logic [TDATA_W-1:0] in_tdata,  // element_value
  input  logic               in_tlast,  // end_of_matrix
  input  logic               out_tvalid,
  input  logic               out_tready,
  input  logic [TDATA_W-1:0] out_tdata, // prime_value
  input  logic               out_tuser, // is_prime
  input  logic               out_tlast, // last_result
  output int                 mismatch_count,
  output int                 outstanding_results
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REPORT_LIMIT = 10;

  typedef struct {
    value_t value;
    logic   prime;
    logic   last;
  } element_result_t;

  element_result_t awaited_results[$];
  int              fails = 0;
  int              awaited_count = 0;

  assign mismatch_count      = fails;
  assign outstanding_results = awaited_count;

  // trial division on the signed value, nothing below two is prime
  function automatic logic value_is_prime(input value_t value);
    longint n;
    longint d;
    logic   prime;
    n = longint'($signed(value));
    if (n < 2) return 1'b0;
    prime = 1'b1;
    for (d = 2; d * d <= n && prime; d++) begin
      if (n % d == 0) prime = 1'b0;
    end
    return prime;
  endfunction

  always @(posedge clk) begin
    element_result_t seen;
    element_result_t want;
    logic            prime;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        seen.value = out_tdata[VALUE_WIDTH-1:0];
        seen.prime = out_tuser;
        seen.last  = out_tlast;
        if (awaited_results.size() == 0) begin
          fails++;
          if (fails <= REPORT_LIMIT)
            $display("%0t unexpected result: value %0d prime %0b last %0b",
                     $realtime, $signed(seen.value), seen.prime, seen.last);
        end else begin
          want = awaited_results.pop_front();
          if (seen.value !== want.value || seen.prime !== want.prime ||
              seen.last !== want.last) begin
            fails++;
            if (fails <= REPORT_LIMIT)
              $display("%0t result mismatch: expected value %0d prime %0b last %0b, %s",
                       $realtime, $signed(want.value), want.prime, want.last,
                       $sformatf("got value %0d prime %0b last %0b",
                                 $signed(seen.value), seen.prime, seen.last));
          end
        end
      end
      if (in_tvalid && in_tready) begin
        prime = value_is_prime(in_tdata[VALUE_WIDTH-1:0]);
        if (prime || in_tlast) begin
          want.value = in_tdata[VALUE_WIDTH-1:0];
          want.prime = prime;
          want.last  = in_tlast;
          awaited_results.push_back(want);
        end
      end
      awaited_count = awaited_results.size();
    end
  end

endmodule

[tb/prime_value_filter_tb.sv]
module prime_value_filter_tb;
  import pvf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     RANDOM_ELEMENTS = 200;
  localparam int     HOLD_CYCLES     = 600;
  localparam int     DRAIN_CYCLES    = 4000;
  localparam longint CYCLE_LIMIT     = 4_000_000;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_tvalid;
  logic               in_tready;
  logic [TDATA_W-1:0] in_tdata;  // element_value
  logic               in_tlast;  // end_of_matrix
  logic               out_tvalid;
  logic               out_tready;
  logic [TDATA_W-1:0] out_tdata; // prime_value
  logic               out_tuser; // is_prime
  logic               out_tlast; // last_result

  int     mismatch_count;
  int     outstanding_results;
  int     elements_sent = 0;
  longint cycle_count = 0;
  logic   tx_burst = 1'b0;
  logic   hold_request = 1'b0;
  logic   rx_hold;
  int     directed_values[$];
  int     directed_last[$];

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  prime_value_filter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  prime_value_filter_checker checker_i (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_tvalid           (in_tvalid),
    .in_tready           (in_tready),
    .in_tdata            (in_tdata),
    .in_tlast            (in_tlast),
    .out_tvalid          (out_tvalid),
    .out_tready          (out_tready),
    .out_tdata           (out_tdata),
    .out_tuser           (out_tuser),
    .out_tlast           (out_tlast),
    .mismatch_count      (mismatch_count),
    .outstanding_results (outstanding_results)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("prime_value_filter regression: fail");
      $finish;
    end
  end

  // mostly small values so primes are common, some wide and negative ones
  function automatic value_t pick_element();
    int mode;
    mode = $urandom_range(0, 9);
    if (mode < 5) return value_t'($urandom_range(0, 200));
    if (mode < 7) return value_t'($urandom_range(0, 4095));
    if (mode == 7) return value_t'(-int'($urandom_range(1, 2 ** (VALUE_WIDTH - 1))));
    return value_t'($urandom);
  endfunction

  task automatic send_element(input value_t value, input logic last);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= TDATA_W'(value);
    in_tlast  <= last;
    do @(posedge clk); while (!(in_tvalid && in_tready));
    elements_sent++;
  endtask

  // long receiver stall so the output register fills and input backs up
  initial begin
    rx_hold <= 1'b0;
    wait (hold_request);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  initial begin
    int   gap;
    logic rx_burst;
    rx_burst = 1'b0;
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if ($urandom_range(0, 15) == 0) rx_burst = ~rx_burst;
      gap = rx_burst ? 0 : $urandom_range(0, 9);
      if (gap > 0 || rx_hold) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
        while (rx_hold) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
    end
  end

  initial begin
    int matrix_size;
    int i;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tlast  <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // extremes, squares of primes, negatives and every kind of matrix end
    directed_values = '{0, 1, 2, 3, 4, 32767, -32768, -1, -7, 32749, 32761,
                        25, 49, 97, 21845, -21846, 13, 8, 0, -5, 1, 2};
    directed_last   = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0,
                        0, 0, 0, 0, 0, 1, 1, 1, 1, 1, 1};
    for (i = 0; i < directed_values.size(); i++)
      send_element(value_t'(directed_values[i]), directed_last[i][0]);

    hold_request <= 1'b1;
    while (elements_sent < directed_values.size() + RANDOM_ELEMENTS) begin
      matrix_size = $urandom_range(1, 12);
      tx_burst    = ($urandom_range(0, 3) == 0);
      for (i = 0; i < matrix_size; i++)
        send_element(pick_element(), i == matrix_size - 1);
    end
    in_tvalid <= 1'b0;
    in_tlast  <= 1'b0;

    while (outstanding_results != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("prime_value_filter regression: pass");
    end else begin
      $display("prime_value_filter regression: fail");
    end
    $finish;
  end

endmodule
